// ----- rtl/core/tn26_pkg.sv -----
// Shared constants for the 26-connected topological number block.
`timescale 1ns / 1ps

package tn26_pkg;

  // Neighborhood geometry
  localparam int NbhVoxels  = 27;
  localparam int NbhCentre  = 13;
  localparam int NumOctants = 8;

  // Result width: counts run from 0 to NumOctants
  localparam int CountW = $clog2(NumOctants + 1);

  typedef logic [NbhVoxels-1:0] nbh_mask_t;
  typedef logic [CountW-1:0]    comp_count_t;

endpackage

// ----- rtl/core/tn26_stream_if.sv -----
// Valid/ready stream interfaces for neighborhood masks and component counts.
`timescale 1ns / 1ps

interface tn26_mask_if;
  import tn26_pkg::*;

  logic      valid;
  logic      ready;
  nbh_mask_t neighbor_mask;

  modport source (output valid, output neighbor_mask, input ready);
  modport sink   (input valid, input neighbor_mask, output ready);
endinterface

interface tn26_count_if;
  import tn26_pkg::*;

  logic        valid;
  logic        ready;
  comp_count_t component_count;

  modport source (output valid, output component_count, input ready);
  modport sink   (input valid, input component_count, output ready);
endinterface

// ----- rtl/core/topological_number_t26.sv -----
// Top level: 26-connected topological number T26 of a 3x3x3 neighborhood.
//
// Usage:
//   mask_i carries one 27-bit neighborhood per transaction, bit k for voxel
//   k = x + 3*y + 9*z; the centre bit is ignored. count_o returns, for each
//   accepted mask, the number of 26-connected components among the 26
//   neighbors (0 to 8), in order.
//   The mask is registered, the count is formed from it by combinational
//   logic and registered again to drive count_o.
//   Throughput is one neighborhood per cycle while the receiver keeps
//   count_o.ready high, through the two-stage register pipeline.
//   The neighbors are grouped into the eight 2x2x2 octants around the
//   centre; two octants join when a set voxel lies in both, and the octant
//   graph is closed by three matrix squarings.
//   Reset empties both stages; no transaction is in flight afterwards.
//   When the receiver stalls, the result holds in the output register while
//   the input register still takes one more mask; mask_i.ready drops only
//   when both stages are full.
`timescale 1ns / 1ps

module topological_number_t26 (
  input  logic  clk_i,
  input  logic  rst_ni,
  tn26_mask_if.sink    mask_i,
  tn26_count_if.source count_o
);
  import tn26_pkg::*;

  typedef logic [NumOctants-1:0][NumOctants-1:0] oct_mat_t;

  // Voxel membership of each octant; octant bit a picks the low or high
  // half-range on axis a, and every octant includes coordinate 1.
  function automatic logic [NumOctants-1:0][NbhVoxels-1:0] build_members();
    logic [NumOctants-1:0][NbhVoxels-1:0] m;
    int ox, oy, oz;
    m = '0;
    for (int o = 0; o < NumOctants; o++) begin
      ox = o[0] ? 2 : 0;
      oy = o[1] ? 2 : 0;
      oz = o[2] ? 2 : 0;
      for (int z = 0; z < 3; z++) begin
        for (int y = 0; y < 3; y++) begin
          for (int x = 0; x < 3; x++) begin
            if ((x == ox || x == 1) && (y == oy || y == 1) && (z == oz || z == 1)) begin
              m[o][x + 3 * y + 9 * z] = 1'b1;
            end
          end
        end
      end
    end
    return m;
  endfunction

  // One closure step: r | r*r over the boolean semiring
  function automatic oct_mat_t square_step(oct_mat_t r);
    oct_mat_t s;
    s = r;
    for (int i = 0; i < NumOctants; i++) begin
      for (int j = 0; j < NumOctants; j++) begin
        for (int k = 0; k < NumOctants; k++) begin
          s[i][j] = s[i][j] | (r[i][k] & r[k][j]);
        end
      end
    end
    return s;
  endfunction

  localparam logic [NumOctants-1:0][NbhVoxels-1:0] OctMembers = build_members();
  localparam nbh_mask_t CentreMask = nbh_mask_t'(1) << NbhCentre;

  logic        in_ready;
  logic        out_adv;
  logic        s1_valid_q;
  nbh_mask_t   mask_q;
  logic        out_valid_q;
  comp_count_t count_q;
  comp_count_t count_d;

  nbh_mask_t                mask_live;
  logic [NumOctants-1:0]    occ;
  oct_mat_t                 reach0, reach1, reach2, reach3;
  logic [NumOctants-1:0]    root;

  // Advance a stage when the one after it is empty or draining
  assign out_adv       = !out_valid_q || count_o.ready;
  assign in_ready      = !s1_valid_q || out_adv;
  assign mask_i.ready  = in_ready;
  assign count_o.valid = out_valid_q;
  assign count_o.component_count = count_q;

  // Octant occupancy and direct links through shared set voxels
  always_comb begin
    mask_live = mask_q & ~CentreMask;
    for (int i = 0; i < NumOctants; i++) begin
      occ[i] = |(mask_live & OctMembers[i]);
    end
    for (int i = 0; i < NumOctants; i++) begin
      for (int j = 0; j < NumOctants; j++) begin
        if (i == j) begin
          reach0[i][j] = occ[i];
        end else begin
          reach0[i][j] = |(mask_live & OctMembers[i] & OctMembers[j]);
        end
      end
    end
  end

  // Close the link graph: paths up to eight octants long
  always_comb begin
    reach1 = square_step(reach0);
    reach2 = square_step(reach1);
    reach3 = square_step(reach2);
  end

  // Count one root per component: the lowest occupied octant it reaches
  always_comb begin
    count_d = '0;
    for (int i = 0; i < NumOctants; i++) begin
      root[i] = occ[i];
      for (int j = 0; j < i; j++) begin
        if (reach3[i][j]) begin
          root[i] = 1'b0;
        end
      end
      count_d = count_d + comp_count_t'(root[i]);
    end
  end

  // Input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= mask_i.valid;
    end
  end

  // Input stage data
  always_ff @(posedge clk_i) begin
    if (in_ready && mask_i.valid) begin
      mask_q <= mask_i.neighbor_mask;
    end
  end

  // Output stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Output stage data
  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      count_q <= count_d;
    end
  end

endmodule

// ----- rtl/core/tn26_checker.sv -----
// Port-level assertions for the topological number block, with their bind.
`timescale 1ns / 1ps

module tn26_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          mask_valid_i,
  input logic                          mask_ready_i,
  input logic                          count_valid_i,
  input logic                          count_ready_i,
  input logic [tn26_pkg::CountW-1:0]   component_count_i
);
  import tn26_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_valid_i && !count_ready_i |=> count_valid_i)
    else $error("stalled result dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_valid_i && !count_ready_i |=> $stable(component_count_i))
    else $error("stalled result changed");

  // Never more components than octants
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_valid_i |-> component_count_i <= CountW'(NumOctants))
    else $error("component count out of range");

  // An empty output stage lets the input side move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !count_valid_i |-> mask_ready_i)
    else $error("input stalled with output stage empty");

  // An accepted mask with the output stage empty meanwhile passes both registers and shows up as a valid count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_valid_i && mask_ready_i && !count_valid_i ##1 !count_valid_i
      |=> count_valid_i)
    else $error("accepted mask produced no result");

endmodule

bind topological_number_t26 tn26_checker u_tn26_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .mask_valid_i      (mask_i.valid),
  .mask_ready_i      (mask_i.ready),
  .count_valid_i     (count_o.valid),
  .count_ready_i     (count_o.ready),
  .component_count_i (count_o.component_count)
);

// ----- sim/tn26_count_checker.sv -----
// Checker for the T26 block: predicts component counts and compares them with count_o.
`timescale 1ns / 1ps

module tn26_count_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  tn26_mask_if        mask_mon,
  tn26_count_if       count_mon,
  output int unsigned err_count_o,
  output int unsigned pending_o
);
  import tn26_pkg::*;

  typedef struct {
    nbh_mask_t   mask;
    comp_count_t count;
  } due_count_t;

  // Neighbors 26-adjacent to each voxel, centre excluded
  nbh_mask_t  reach [NbhVoxels];
  due_count_t due_counts [$];
  int unsigned mismatches;

  initial begin
    int dx, dy, dz;
    for (int p = 0; p < NbhVoxels; p++) begin
      reach[p] = '0;
      for (int q = 0; q < NbhVoxels; q++) begin
        dx = (p % 3) - (q % 3);
        dy = ((p / 3) % 3) - ((q / 3) % 3);
        dz = (p / 9) - (q / 9);
        if (q != NbhCentre && dx >= -1 && dx <= 1 && dy >= -1 && dy <= 1 &&
            dz >= -1 && dz <= 1) begin
          reach[p][q] = 1'b1;
        end
      end
    end
  end

  // Peel off one 26-connected component at a time, grown from its lowest voxel
  function automatic comp_count_t count_components(nbh_mask_t mask);
    nbh_mask_t left, grp, grown;
    int unsigned n;
    left = mask;
    left[NbhCentre] = 1'b0;
    n = 0;
    while (left != '0) begin
      grown = left & (~left + 1'b1);
      do begin
        grp = grown;
        for (int p = 0; p < NbhVoxels; p++) begin
          if (grp[p]) grown |= reach[p];
        end
        grown &= left;
      end while (grown != grp);
      left &= ~grp;
      n++;
    end
    return comp_count_t'(n);
  endfunction

  // Compare each count transaction first, then queue the prediction for a new mask
  always @(posedge clk_i or negedge rst_ni) begin
    due_count_t head;
    due_count_t fresh;
    if (!rst_ni) begin
      due_counts.delete();
      mismatches = 0;
      err_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (count_mon.valid && count_mon.ready) begin
        if (due_counts.size() == 0) begin
          $display("%0t: count %0d arrived with no mask outstanding",
                   $time, count_mon.component_count);
          mismatches++;
        end else begin
          head = due_counts.pop_front();
          if (count_mon.component_count !== head.count) begin
            $display("%0t: mask %h: expected count %0d, actual %0d",
                     $time, head.mask, head.count, count_mon.component_count);
            mismatches++;
          end
        end
      end
      if (mask_mon.valid && mask_mon.ready) begin
        fresh.mask = mask_mon.neighbor_mask;
        fresh.count = count_components(mask_mon.neighbor_mask);
        due_counts.push_back(fresh);
      end
      err_count_o <= mismatches;
      pending_o <= due_counts.size();
    end
  end

endmodule

// ----- sim/tb_topological_number_t26.sv -----
// Testbench top for the T26 block: clock, reset, mask and count traffic, verdict.
`timescale 1ns / 1ps

module tb_topological_number_t26;
  import tn26_pkg::*;

  localparam int unsigned RandomMasks = 1800;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned LongHold    = 80;

  localparam nbh_mask_t AllSet     = 27'h7FFFFFF;
  localparam nbh_mask_t CentreOnly = 27'h0002000;
  localparam nbh_mask_t CornerMask = 27'h5140145;
  localparam nbh_mask_t FaceMask   = 27'h0415410;
  localparam nbh_mask_t EdgeMask   = 27'h2AA8AAA;

  logic        clk_i;
  logic        rst_ni;
  int unsigned err_count;
  int unsigned pending;
  int unsigned masks_sent;
  int unsigned cycles;
  bit          rx_hold;

  tn26_mask_if  mask_ch ();
  tn26_count_if count_ch ();

  topological_number_t26 dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mask_i (mask_ch),
    .count_o(count_ch)
  );

  tn26_count_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mask_mon   (mask_ch),
    .count_mon  (count_ch),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_topological_number_t26: errors");
      $finish;
    end
  end

  // Mixed densities: dense, sparse, corner-heavy and nearly full neighborhoods
  function automatic nbh_mask_t make_mask();
    nbh_mask_t m;
    int unsigned kind, fill;
    kind = $urandom_range(0, 4);
    m = '0;
    case (kind)
      0: m = nbh_mask_t'($urandom());
      1, 2: begin
        fill = $urandom_range(1, 15);
        for (int k = 0; k < NbhVoxels; k++) m[k] = ($urandom_range(0, 15) < fill);
      end
      3: begin
        m = CornerMask & nbh_mask_t'($urandom());
        for (int k = 0; k < NbhVoxels; k++) begin
          if ($urandom_range(0, 19) == 0) m[k] = 1'b1;
        end
      end
      default: begin
        m = AllSet;
        for (int k = 0; k < NbhVoxels; k++) begin
          if ($urandom_range(0, 5) == 0) m[k] = 1'b0;
        end
      end
    endcase
    return m;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap(int unsigned idx);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (rx_hold || (idx / 150) % 4 == 1) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // Hold valid low for the gap, then offer the mask until the transaction completes
  task automatic offer_mask(nbh_mask_t m, int unsigned gap);
    repeat (gap) @(negedge clk_i) mask_ch.valid <= 1'b0;
    @(negedge clk_i);
    mask_ch.valid <= 1'b1;
    mask_ch.neighbor_mask <= m;
    do @(posedge clk_i); while (!mask_ch.ready);
    masks_sent++;
  endtask

  // Stop offering and wait for every outstanding count
  task automatic drain();
    @(negedge clk_i) mask_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Receiver: random stalls, one long hold-off while the sender keeps pushing
  initial begin
    int unsigned off, on, r;
    bit held;
    count_ch.ready = 1'b0;
    rx_hold = 1'b0;
    held = 1'b0;
    on = 1;
    @(posedge rst_ni);
    forever begin
      if (!held && masks_sent >= 400) begin
        held = 1'b1;
        rx_hold = 1'b1;
        @(negedge clk_i) count_ch.ready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
        rx_hold = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) off = 0;
        else if (r < 75) off = $urandom_range(1, 2);
        else if (r < 95) off = $urandom_range(3, 8);
        else off = $urandom_range(20, 40);
        on = (r % 10 == 0) ? $urandom_range(50, 120) : $urandom_range(1, 20);
        if (off > 0) begin
          @(negedge clk_i) count_ch.ready <= 1'b0;
          repeat (off - 1) @(negedge clk_i);
        end
      end
      @(negedge clk_i) count_ch.ready <= 1'b1;
      repeat (on - 1) @(negedge clk_i);
    end
  end

  // Sender: directed corner cases, then random neighborhoods
  initial begin
    nbh_mask_t directed [$];
    masks_sent = 0;
    rst_ni = 1'b0;
    mask_ch.valid = 1'b0;
    mask_ch.neighbor_mask = '0;
    directed = '{
      27'h0000000, AllSet, CentreOnly, AllSet & ~CentreOnly,
      CornerMask, CornerMask | CentreOnly, FaceMask, EdgeMask,
      FaceMask | CornerMask, 27'h0000001, 27'h4000000, 27'h0000010,
      27'h4000001, 27'h0000003, 27'h0000005, 27'h5555555, 27'h2AAAAAA,
      27'h0000145, 27'h5140000
    };
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (directed[i]) offer_mask(directed[i], $urandom_range(0, 2));
    drain();

    for (int unsigned i = 0; i < RandomMasks; i++) begin
      if (i == RandomMasks / 2) drain();
      offer_mask(make_mask(), pick_gap(i));
    end
    drain();
    repeat (10) @(negedge clk_i);

    if (err_count == 0 && pending == 0) begin
      $display("tb_topological_number_t26: clean");
    end else begin
      $display("tb_topological_number_t26: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tn26_pkg.sv
rtl/core/tn26_stream_if.sv
rtl/core/topological_number_t26.sv
rtl/core/tn26_checker.sv
sim/tn26_count_checker.sv
sim/tb_topological_number_t26.sv
